FILE: hdl/chacha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared constants, types and the quarter-round helper for the cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int unsigned DoubleRoundsDef = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegKeyLow     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyMidLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyMidHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyHigh    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonceLow   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonceHigh  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCtrStart   = 3'd6;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Queue entry between front and back
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef enum logic [1:0] {
    CoreIdle,
    CoreRound,
    CoreFinal
  } core_state_e;

  typedef logic [15:0][31:0] words_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic qr_t quarter(input qr_t x);
    qr_t y;
    y = x;
    y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 16);
    y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 12);
    y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 8);
    y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 7);
    quarter = y;
  endfunction

endpackage

FILE: hdl/chacha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 front queue
// Accepts items and holds them in a short queue ahead of the keystream side.
// ----------------------------------------------------------------------------
module chacha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  chacha_pkg::item_t   in_item_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output chacha_pkg::item_t   q_item_o
);

  chacha_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost item");

endmodule

FILE: hdl/chacha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 block core
// One column or diagonal round per cycle over the 16-word state, then
// feed-forward.
// ----------------------------------------------------------------------------
module chacha_core #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  chacha_pkg::words_t  init_i,
  output logic                done_o,
  output chacha_pkg::words_t  block_o
);

  localparam int unsigned HalfRounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RndW = $clog2(HalfRounds + 1);

  chacha_pkg::core_state_e state_q, state_d;
  logic [RndW-1:0]    rnd_q, rnd_d;
  chacha_pkg::words_t init_q, w_q, w_d, col, dia;
  chacha_pkg::qr_t    qo [8];

  // Column round and diagonral round, both from the current words
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qo[i] = chacha_pkg::quarter({w_q[i], w_q[4+i], w_q[8+i], w_q[12+i]});
    end
    col = w_q;
    for (int i = 0; i < 4; i++) begin
      col[i] = qo[i].a; col[4+i] = qo[i].b; col[8+i] = qo[i].c; col[12+i] = qo[i].d;
    end
    for (int i = 0; i < 4; i++) begin
      qo[4+i] = chacha_pkg::quarter({w_q[i], w_q[4+(i+1)%4], w_q[8+(i+2)%4],
                                     w_q[12+(i+3)%4]});
    end
    dia = w_q;
    for (int i = 0; i < 4; i++) begin
      dia[i] = qo[4+i].a; dia[4+(i+1)%4] = qo[4+i].b;
      dia[8+(i+2)%4] = qo[4+i].c; dia[12+(i+3)%4] = qo[4+i].d;
    end
  end

  // Sequencer: even steps are column rounds, odd steps diagonal rounds
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    w_d     = w_q;
    done_o  = 1'b0;
    case (state_q)
      chacha_pkg::CoreIdle: begin
        if (start_i) begin
          w_d     = init_i;
          rnd_d   = '0;
          state_d = chacha_pkg::CoreRound;
        end
      end
      chacha_pkg::CoreRound: begin
        w_d   = rnd_q[0] ? dia : col;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(HalfRounds - 1)) begin
          state_d = chacha_pkg::CoreFinal;
        end
      end
      chacha_pkg::CoreFinal: begin
        for (int i = 0; i < 16; i++) begin
          w_d[i] = w_q[i] + init_q[i];
        end
        done_o  = 1'b1;
        state_d = chacha_pkg::CoreIdle;
      end
      default: state_d = chacha_pkg::CoreIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chacha_pkg::CoreIdle;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (start_i && state_q == chacha_pkg::CoreIdle) begin
      init_q <= init_i;
    end
  end

  // Sum is combinational at done; registered block appears next cycle in w_q
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block_o[i] = w_q[i] + init_q[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == chacha_pkg::CoreIdle) else $error("core not idle after done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chacha_pkg::CoreIdle) |-> !done_o) else $error("done while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chacha_pkg::CoreRound) |-> rnd_q < RndW'(HalfRounds))
    else $error("round count overrun");

endmodule

FILE: hdl/chacha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Pops items, keeps the keystream buffer and counter, drives results.
// ----------------------------------------------------------------------------
module chacha_back #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  chacha_pkg::item_t  q_item_i,
  input  logic [255:0]       key_i,
  input  logic [95:0]        nonce_i,
  input  logic [31:0]        ctr_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_data_o,
  output logic               out_last_o
);

  logic [31:0]        ctr_q;
  logic [6:0]         pos_q;
  logic [511:0]       ks_q;
  logic               busy_q;
  logic               core_start, core_done;
  chacha_pkg::words_t init, blk;
  logic               out_free, is_data, need_blk;

  assign out_free = !out_valid_o || !out_stall_i;
  assign is_data  = q_valid_i && !q_item_i.start;
  assign need_blk = pos_q[6];
  assign q_pop_o  = q_valid_i && (q_item_i.start || (!need_blk && out_free));
  assign core_start = is_data && need_blk && !busy_q;

  // Block input words
  always_comb begin
    init[0] = chacha_pkg::Sigma0;
    init[1] = chacha_pkg::Sigma1;
    init[2] = chacha_pkg::Sigma2;
    init[3] = chacha_pkg::Sigma3;
    for (int i = 0; i < 8; i++) begin
      init[4+i] = key_i[32*i +: 32];
    end
    init[12] = ctr_q;
    for (int i = 0; i < 3; i++) begin
      init[13+i] = nonce_i[32*i +: 32];
    end
  end

  chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .init_i  (init),
    .done_o  (core_done),
    .block_o (blk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      pos_q       <= 7'd64;
      busy_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (core_start) begin
        busy_q <= 1'b1;
      end
      if (core_done) begin
        busy_q <= 1'b0;
        pos_q  <= '0;
        ctr_q  <= ctr_q + 32'd1;
      end else if (q_pop_o && q_item_i.start) begin
        ctr_q <= ctr_start_i;
        pos_q <= 7'd64;
      end else if (q_pop_o) begin
        pos_q <= pos_q + 7'd1;
      end
      if (out_free) begin
        out_valid_o <= q_pop_o && !q_item_i.start;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      ks_q <= blk;
    end
    if (q_pop_o && !q_item_i.start) begin
      out_data_o <= q_item_i.data ^ ks_q[8*pos_q[5:0] +: 8];
      out_last_o <= q_item_i.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> busy_q) else $error("block done without request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_item_i.start) |-> !need_blk) else $error("byte used without keystream");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !(q_pop_o && !q_item_i.start)) else $error("byte popped during block");

endmodule

FILE: hdl/chacha20_stream_cipher.sv
`timescale 1ns / 1ps
// Path: a data byte with keystream buffered goes through the front queue and the output register.
// Throughput: one byte per cycle within a 64-byte block unless the output stalls; a new block
// holds bytes while the core runs one column or diagonal round per cycle, then feed-forward.
// Reset: asynchronous, active low; registers 0, counter 0, no keystream buffered.
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher top
// Config registers, front queue and keystream back end.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_in_i,
  input  logic        last_of_call_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o,
  output logic        last_out_o
);

  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  ctr_start_q;
  logic         q_valid, q_pop;
  chacha_pkg::item_t in_item, q_item;

  assign cfg_ready_o = 1'b1;
  assign in_item = '{start: cmd_i, data: data_in_i, last: last_of_call_i};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_q     <= '0;
      ctr_start_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        chacha_pkg::RegKeyLow:     key_q[63:0]    <= cfg_data_i;
        chacha_pkg::RegKeyMidLow:  key_q[127:64]  <= cfg_data_i;
        chacha_pkg::RegKeyMidHigh: key_q[191:128] <= cfg_data_i;
        chacha_pkg::RegKeyHigh:    key_q[255:192] <= cfg_data_i;
        chacha_pkg::RegNonceLow:   nonce_q[63:0]  <= cfg_data_i;
        chacha_pkg::RegNonceHigh:  nonce_q[95:64] <= cfg_data_i[31:0];
        chacha_pkg::RegCtrStart:   ctr_start_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  chacha_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .key_i       (key_q),
    .nonce_i     (nonce_q),
    .ctr_start_i (ctr_start_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (data_out_o),
    .out_last_o  (last_out_o)
  );

endmodule

FILE: tb/sv/tb_chacha20_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Drives bytes and start items through the cipher under bursty input traffic
// and a random output stall. Each output byte is checked against a software
// ChaCha20 keystream kept in step with the block. Key, nonce and start
// counter change between phases, the extremes and the counter wrap among them.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher;

  localparam int unsigned SettleCycles = 48;
  localparam int unsigned CycleLimit   = 600000;

  // One input item, with an optional typed expectation
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       last;
    logic       chk;
    logic [7:0] exp_data;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [7:0]  data_in_i = '0;
  logic        last_of_call_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  data_out_o;
  logic        last_out_o;

  chacha20_stream_cipher dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Model copy of registers and keystream state
  logic [63:0] m_key [4];
  logic [63:0] m_nonce_lo;
  logic [31:0] m_nonce_hi;
  logic [31:0] m_ctr_start;
  logic [31:0] m_ctr;
  logic [7:0]  m_ks [64];
  int unsigned m_pos;
  logic [31:0] wk [16];

  stim_t       stim_q [$];
  cipher_out_t cipher_q [$];
  stim_t       cur;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void qround(int a, int b, int c, int d);
    wk[a] = wk[a] + wk[b]; wk[d] = rol32(wk[d] ^ wk[a], 16);
    wk[c] = wk[c] + wk[d]; wk[b] = rol32(wk[b] ^ wk[c], 12);
    wk[a] = wk[a] + wk[b]; wk[d] = rol32(wk[d] ^ wk[a], 8);
    wk[c] = wk[c] + wk[d]; wk[b] = rol32(wk[b] ^ wk[c], 7);
  endfunction

  // Build the next 64 keystream bytes and step the block counter
  function void refill_keystream();
    logic [31:0] init [16];
    logic [31:0] v;
    init[0] = chacha_pkg::Sigma0; init[1] = chacha_pkg::Sigma1;
    init[2] = chacha_pkg::Sigma2; init[3] = chacha_pkg::Sigma3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = m_key[k][31:0];
      init[5 + 2 * k] = m_key[k][63:32];
    end
    init[12] = m_ctr;
    init[13] = m_nonce_lo[31:0];
    init[14] = m_nonce_lo[63:32];
    init[15] = m_nonce_hi;
    wk = init;
    for (int r = 0; r < chacha_pkg::DoubleRoundsDef; r++) begin
      qround(0, 4, 8, 12);  qround(1, 5, 9, 13);
      qround(2, 6, 10, 14); qround(3, 7, 11, 15);
      qround(0, 5, 10, 15); qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);  qround(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      v = wk[i] + init[i];
      for (int j = 0; j < 4; j++) m_ks[4 * i + j] = v[8 * j +: 8];
    end
    m_ctr = m_ctr + 32'd1;
  endfunction

  // Advance the model by one accepted item and queue the expected byte
  function void predict_cipher(stim_t s);
    cipher_out_t e;
    if (s.cmd) begin
      m_ctr = m_ctr_start;
      m_pos = 64;
    end else begin
      if (m_pos >= 64) begin
        refill_keystream();
        m_pos = 0;
      end
      e.data = s.data ^ m_ks[m_pos];
      e.last = s.last;
      m_pos++;
      if (s.chk) e.data = s.exp_data;
      cipher_q.push_back(e);
    end
  endfunction

  // Input side: bursts with random gaps; also the output compare
  always @(posedge clk_i) begin
    cipher_out_t e;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_cipher(cur);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          cmd_i <= cur.cmd;
          data_in_i <= cur.data;
          last_of_call_i <= cur.last;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end

      if (out_valid_o && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output byte %02h", data_out_o);
        end else begin
          e = cipher_q.pop_front();
          if (e.data !== data_out_o || e.last !== last_out_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp data %02h last %0b, got data %02h last %0b",
                       e.data, e.last, data_out_o, last_out_o);
          end
        end
      end

      // Receiver stall pattern: none, light or heavy random stall, or a fixed periodic one, drawn at random
      if (cycles % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((cycles / 5) % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("[chacha20_stream_cipher] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      chacha_pkg::RegKeyLow:     m_key[0] = val;
      chacha_pkg::RegKeyMidLow:  m_key[1] = val;
      chacha_pkg::RegKeyMidHigh: m_key[2] = val;
      chacha_pkg::RegKeyHigh:    m_key[3] = val;
      chacha_pkg::RegNonceLow:   m_nonce_lo = val;
      chacha_pkg::RegNonceHigh:  m_nonce_hi = val[31:0];
      chacha_pkg::RegCtrStart:   m_ctr_start = val[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (stim_q.size() > 0 || in_valid_i || cipher_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_reg(int unsigned flavor);
    case (flavor)
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic stim_t data_item(logic [7:0] d, logic l);
    return '{cmd: 1'b0, data: d, last: l, chk: 1'b0, exp_data: 8'h00};
  endfunction

  // Directed rows: RFC 7539 sunscreen vector head, then field extremes
  stim_t dir_tbl [22] = '{
    '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h4c, 1'b0, 1'b1, 8'h6e},
    '{1'b0, 8'h61, 1'b0, 1'b1, 8'h2e},
    '{1'b0, 8'h64, 1'b0, 1'b1, 8'h35},
    '{1'b0, 8'h69, 1'b0, 1'b1, 8'h9a},
    '{1'b0, 8'h65, 1'b0, 1'b1, 8'h25},
    '{1'b0, 8'h73, 1'b0, 1'b1, 8'h68},
    '{1'b0, 8'h20, 1'b0, 1'b1, 8'hf9},
    '{1'b0, 8'h61, 1'b1, 1'b1, 8'h80},
    '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'hff, 1'b1, 1'b0, 8'h00},
    '{1'b1, 8'hff, 1'b1, 1'b0, 8'h00},
    '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00},
    '{1'b0, 8'hff, 1'b0, 1'b0, 8'h00},
    '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b1, 8'h5a, 1'b1, 1'b0, 8'h00},
    '{1'b0, 8'ha5, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h5a, 1'b1, 1'b0, 8'h00},
    '{1'b0, 8'h80, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h01, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h7f, 1'b1, 1'b0, 8'h00},
    '{1'b0, 8'hfe, 1'b0, 1'b0, 8'h00}
  };

  initial begin
    stim_t s;
    int unsigned n;
    int unsigned flavor;
    m_key = '{default: '0};
    m_nonce_lo = '0;
    m_nonce_hi = '0;
    m_ctr_start = '0;
    m_ctr = '0;
    m_pos = 64;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Data straight after reset: counter 0, all-zero key and nonce
    for (int i = 0; i < 3; i++) stim_q.push_back(data_item(8'($urandom), 1'($urandom)));
    wait_drained();

    write_reg(chacha_pkg::RegKeyLow,     64'h0706050403020100);
    write_reg(chacha_pkg::RegKeyMidLow,  64'h0f0e0d0c0b0a0908);
    write_reg(chacha_pkg::RegKeyMidHigh, 64'h1716151413121110);
    write_reg(chacha_pkg::RegKeyHigh,    64'h1f1e1d1c1b1a1918);
    write_reg(chacha_pkg::RegNonceLow,   64'h4a00000000000000);
    write_reg(chacha_pkg::RegNonceHigh,  64'h0);
    write_reg(chacha_pkg::RegCtrStart,   64'h1);
    foreach (dir_tbl[i]) stim_q.push_back(dir_tbl[i]);
    wait_drained();

    // Random phases: new settings in most, counter wrap in some
    for (int ph = 0; ph < 14; ph++) begin
      flavor = (ph < 2) ? ph : 2;
      for (int r = 0; r < 6; r++) begin
        if ($urandom_range(0, 3) != 0 || ph < 2)
          write_reg(3'(r), (ph < 2) ? rand_reg(flavor) : rand_reg($urandom_range(0, 5)));
      end
      case ($urandom_range(0, 3))
        0: write_reg(chacha_pkg::RegCtrStart, 64'hffff_ffff);
        1: write_reg(chacha_pkg::RegCtrStart, 64'hffff_fffe);
        2: write_reg(chacha_pkg::RegCtrStart, {$urandom, $urandom});
        default: ;
      endcase
      if (ph % 3 == 0) write_reg(3'd7, {$urandom, $urandom});
      // Most phases restart the stream; others keep buffered keystream
      if ($urandom_range(0, 4) != 0) begin
        s = data_item(8'($urandom), 1'($urandom));
        s.cmd = 1'b1;
        stim_q.push_back(s);
      end
      n = $urandom_range(100, 160);
      for (int i = 0; i < n; i++) begin
        s = data_item(8'($urandom), ($urandom_range(0, 7) == 0));
        s.cmd = ($urandom_range(0, 49) == 0);
        stim_q.push_back(s);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("[chacha20_stream_cipher] OK");
    end else begin
      $display("[chacha20_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
